>>> rtl/tcp_port_scan_detector_core_assert.svh
// Assertion helpers for the port scan detector.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef TCP_PORT_SCAN_DETECTOR_CORE_ASSERT_SVH
`define TCP_PORT_SCAN_DETECTOR_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TPSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define TPSD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/tpsd_pkg.sv
package tpsd_pkg;

  // Frame length limits in bytes.
  localparam logic [15:0] MIN_FRAME = 16'd34;
  localparam logic [6:0]  ETH_BYTES = 7'd14;
  localparam logic [6:0]  TCP_BYTES = 7'd20;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  // Register reset values.
  localparam logic [7:0] WINDOW_RESET      = 8'd5;
  localparam logic [2:0] PORT_THR_RESET    = 3'd5;
  localparam logic [7:0] SYN_RST_RESET     = 8'd1;
  localparam logic [3:0] STEALTH_THR_RESET = 4'd3;

  typedef enum logic [1:0] {
    CFG_WINDOW,
    CFG_PORT_THR,
    CFG_SYN_RST,
    CFG_STEALTH_THR
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRC_RD,
    ST_SRC_CMP,
    ST_ALLOC,
    ST_REC_RD,
    ST_APPLY,
    ST_SLOT_RD,
    ST_SLOT_CMP,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_QUICK,
    RES_MISS,
    RES_FULL
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     scan_rd;
    logic     scan_step;
    logic     alloc;
    logic     rec_rd;
    logic     apply;
    logic     slot_rd;
    logic     slot_step;
    logic     commit;
    res_sel_e res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_ignore;
    logic in_active;
    logic syn_open;
    logic src_match;
    logic scan_last;
    logic free_found;
    logic n_zero;
    logic slot_match;
    logic slot_last;
  } sts_t;

endpackage

>>> rtl/tcp_port_scan_detector_core.sv
// Sequence: a dropped frame, or one with neither RST nor SYN-without-ACK, answers from idle;
// else each table entry is read and compared up to a match or the last entry. A source neither
// found nor tracked ends there; else its record is read or a new entry taken, applied, for a SYN
// the port slots walked, and the record committed. Throughput: one item at a time, the next
// transfer in the cycle its result shows. The receiver cannot stall: results last 1 cycle.
// Reset: rst_ni clears valid bits, control and registers to defaults; no clearing pass.
module tcp_port_scan_detector_core import tpsd_pkg::*; #(
  parameter int SOURCE_ENTRIES = 64,
  parameter int PORT_SLOTS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [15:0] frame_length_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [3:0]  header_words_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] dest_port_i,
  input  logic        syn_flag_i,
  input  logic        ack_flag_i,
  input  logic        rst_flag_i,
  input  logic [31:0] now_seconds_i,
  output logic        result_valid_o,
  output logic        ignored_o,
  output logic        stealth_pattern_o,
  output logic [3:0]  stealth_count_o,
  output logic        stealth_alert_o,
  output logic        sweep_alert_o,
  output logic [3:0]  unique_ports_o,
  output logic        table_full_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tpsd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Table, port sets and result registers.
  tpsd_datapath #(
    .SOURCE_ENTRIES (SOURCE_ENTRIES),
    .PORT_SLOTS     (PORT_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .frame_length_i    (frame_length_i),
    .ip_protocol_i     (ip_protocol_i),
    .header_words_i    (header_words_i),
    .source_address_i  (source_address_i),
    .dest_port_i       (dest_port_i),
    .syn_flag_i        (syn_flag_i),
    .ack_flag_i        (ack_flag_i),
    .rst_flag_i        (rst_flag_i),
    .now_seconds_i     (now_seconds_i),
    .result_valid_o    (result_valid_o),
    .ignored_o         (ignored_o),
    .stealth_pattern_o (stealth_pattern_o),
    .stealth_count_o   (stealth_count_o),
    .stealth_alert_o   (stealth_alert_o),
    .sweep_alert_o     (sweep_alert_o),
    .unique_ports_o    (unique_ports_o),
    .table_full_o      (table_full_o)
  );

endmodule

>>> rtl/tpsd_ctrl.sv
module tpsd_ctrl import tpsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.res_sel = RES_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_ignore || !sts_i.in_active) begin
            cmd_o.res_sel = RES_QUICK;
          end else begin
            state_d = ST_SRC_RD;
          end
        end
      end
      ST_SRC_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = ST_SRC_CMP;
      end
      ST_SRC_CMP: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.src_match) begin
          state_d = ST_REC_RD;
        end else if (sts_i.scan_last) begin
          if (sts_i.syn_open && sts_i.free_found) begin
            state_d = ST_ALLOC;
          end else begin
            cmd_o.res_sel = RES_MISS;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_SRC_RD;
        end
      end
      ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d = ST_APPLY;
      end
      ST_REC_RD: begin
        cmd_o.rec_rd = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.syn_open && !sts_i.n_zero) begin
          state_d = ST_SLOT_RD;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SLOT_RD: begin
        cmd_o.slot_rd = 1'b1;
        state_d = ST_SLOT_CMP;
      end
      ST_SLOT_CMP: begin
        cmd_o.slot_step = 1'b1;
        if (sts_i.slot_match || sts_i.slot_last) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_SLOT_RD;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.res_sel = RES_FULL;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> rtl/tpsd_datapath.sv
`include "tcp_port_scan_detector_core_assert.svh"

module tpsd_datapath import tpsd_pkg::*; #(
  parameter int SOURCE_ENTRIES = 64,
  parameter int PORT_SLOTS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [15:0] frame_length_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [3:0]  header_words_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] dest_port_i,
  input  logic        syn_flag_i,
  input  logic        ack_flag_i,
  input  logic        rst_flag_i,
  input  logic [31:0] now_seconds_i,
  output logic        result_valid_o,
  output logic        ignored_o,
  output logic        stealth_pattern_o,
  output logic [3:0]  stealth_count_o,
  output logic        stealth_alert_o,
  output logic        sweep_alert_o,
  output logic [3:0]  unique_ports_o,
  output logic        table_full_o
);

  localparam int EW  = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
  localparam int KW  = $clog2(PORT_SLOTS);
  localparam int CW  = $clog2(PORT_SLOTS + 1);
  localparam int SAW = $clog2(SOURCE_ENTRIES * PORT_SLOTS);
  localparam int RW  = 68 + CW;

  // Configuration registers.
  logic [7:0] win_q, syn_rst_q;
  logic [2:0] port_thr_q;
  logic [3:0] stealth_thr_q;

  // Table storage.
  logic [SOURCE_ENTRIES-1:0] valid_q;
  logic [31:0]   src_mem  [SOURCE_ENTRIES];
  logic [RW-1:0] rec_mem  [SOURCE_ENTRIES];
  logic [15:0]   slot_mem [SOURCE_ENTRIES*PORT_SLOTS];

  // Item and working registers.
  logic [31:0]   addr_q, now_q, src_rd_q, first_q, last_q;
  logic [15:0]   port_q, slot_rd_q;
  logic          syn_open_q, rst_q, vld_rd_q, free_found_q, seen_q;
  logic [EW-1:0] idx_q, free_idx_q, entry_q;
  logic [KW-1:0] k_q;
  logic [CW-1:0] n_q;
  logic [RW-1:0] rec_q;
  logic [3:0]    hits_q, cnt_q;
  logic          pat_q, salert_q;

  // Result registers.
  logic       res_valid_q, ignored_q, pattern_q, stealth_alert_q, sweep_q, full_q;
  logic [3:0] count_q, unique_q;

  // Input screening on the live ports.
  logic [6:0] min_len;
  logic       in_ignore, in_syn_open;
  assign min_len = ETH_BYTES + TCP_BYTES + {1'b0, header_words_i, 2'b00};
  assign in_ignore = (frame_length_i < MIN_FRAME) || (ip_protocol_i != PROTO_TCP) ||
                     (frame_length_i < 16'(min_len));
  assign in_syn_open = syn_flag_i && !ack_flag_i;

  // Record fields.
  logic [31:0]   rec_first, rec_last, first_diff, last_diff;
  logic [3:0]    rec_hits, hits_inc;
  logic [CW-1:0] rec_count, n_next;
  logic          rst_hit, restart, hit_alert;
  assign rec_first  = rec_q[RW-1 -: 32];
  assign rec_last   = rec_q[RW-33 -: 32];
  assign rec_hits   = rec_q[CW+3 -: 4];
  assign rec_count  = rec_q[CW-1:0];
  assign first_diff = now_q - rec_first;
  assign last_diff  = now_q - rec_last;
  assign hits_inc   = rec_hits + 4'd1;
  assign rst_hit    = rst_q && (rec_last != 32'd0) && (last_diff <= {24'd0, syn_rst_q});
  assign hit_alert  = hits_inc >= stealth_thr_q;
  assign restart    = (rec_first == 32'd0) || (first_diff > {24'd0, win_q});
  assign n_next     = (syn_open_q && restart) ? '0 : rec_count;

  // Final port count at commit.
  logic          add_port, walert;
  logic [CW-1:0] n_fin, count_store;
  assign add_port    = syn_open_q && !seen_q && (n_q < CW'(PORT_SLOTS));
  assign n_fin       = add_port ? n_q + CW'(1) : n_q;
  assign walert      = syn_open_q && (8'(n_fin) > 8'(port_thr_q));
  assign count_store = walert ? '0 : n_fin;

  // Slot addresses.
  logic [SAW-1:0] slot_base, slot_rd_addr, slot_wr_addr;
  assign slot_base    = SAW'(entry_q) * SAW'(PORT_SLOTS);
  assign slot_rd_addr = slot_base + SAW'(k_q);
  assign slot_wr_addr = slot_base + SAW'(n_q[KW-1:0]);

  // Status. The entry being compared counts as free when its valid bit is clear.
  always_comb begin
    sts_o.in_ignore  = in_ignore;
    sts_o.in_active  = rst_flag_i || in_syn_open;
    sts_o.syn_open   = syn_open_q;
    sts_o.src_match  = vld_rd_q && (src_rd_q == addr_q);
    sts_o.scan_last  = (idx_q == EW'(SOURCE_ENTRIES - 1));
    sts_o.free_found = free_found_q || !vld_rd_q;
    sts_o.n_zero     = (n_next == '0);
    sts_o.slot_match = (slot_rd_q == port_q);
    sts_o.slot_last  = (CW'(k_q) + CW'(1) == n_q);
  end

  // Configuration, valid bits and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q         <= WINDOW_RESET;
      port_thr_q    <= PORT_THR_RESET;
      syn_rst_q     <= SYN_RST_RESET;
      stealth_thr_q <= STEALTH_THR_RESET;
      valid_q       <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_WINDOW:      win_q <= cfg_wdata_i;
          CFG_PORT_THR:    port_thr_q <= cfg_wdata_i[2:0];
          CFG_SYN_RST:     syn_rst_q <= cfg_wdata_i;
          CFG_STEALTH_THR: stealth_thr_q <= cfg_wdata_i[3:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.alloc) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      res_valid_q <= (cmd_i.res_sel != RES_NONE);
    end
  end

  // Memories and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q       <= source_address_i;
      port_q       <= dest_port_i;
      now_q        <= now_seconds_i;
      syn_open_q   <= in_syn_open;
      rst_q        <= rst_flag_i;
      idx_q        <= '0;
      free_found_q <= 1'b0;
    end
    if (cmd_i.scan_rd) begin
      src_rd_q <= src_mem[idx_q];
      vld_rd_q <= valid_q[idx_q];
    end
    if (cmd_i.scan_step) begin
      if (sts_o.src_match) begin
        entry_q <= idx_q;
      end else begin
        if (!vld_rd_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= idx_q;
        end
        idx_q <= idx_q + EW'(1);
      end
    end
    if (cmd_i.alloc) begin
      src_mem[free_idx_q] <= addr_q;
      entry_q <= free_idx_q;
      rec_q   <= '0;
    end
    if (cmd_i.rec_rd) begin
      rec_q <= rec_mem[entry_q];
    end
    if (cmd_i.apply) begin
      pat_q    <= rst_hit;
      cnt_q    <= rst_hit ? hits_inc : 4'd0;
      salert_q <= rst_hit && hit_alert;
      hits_q   <= rst_hit ? (hit_alert ? 4'd0 : hits_inc) : rec_hits;
      first_q  <= (syn_open_q && restart) ? now_q : rec_first;
      last_q   <= syn_open_q ? now_q : rec_last;
      n_q      <= n_next;
      k_q      <= '0;
      seen_q   <= 1'b0;
    end
    if (cmd_i.slot_rd) begin
      slot_rd_q <= slot_mem[slot_rd_addr];
    end
    if (cmd_i.slot_step) begin
      if (sts_o.slot_match) begin
        seen_q <= 1'b1;
      end
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.commit) begin
      rec_mem[entry_q] <= {first_q, last_q, hits_q, count_store};
      if (add_port) begin
        slot_mem[slot_wr_addr] <= port_q;
      end
    end
  end

  // Result fields, registered alongside the strobe.
  always_ff @(posedge clk_i) begin
    case (cmd_i.res_sel)
      RES_QUICK: begin
        ignored_q       <= in_ignore;
        pattern_q       <= 1'b0;
        count_q         <= 4'd0;
        stealth_alert_q <= 1'b0;
        sweep_q         <= 1'b0;
        unique_q        <= 4'd0;
        full_q          <= 1'b0;
      end
      RES_MISS: begin
        ignored_q       <= 1'b0;
        pattern_q       <= 1'b0;
        count_q         <= 4'd0;
        stealth_alert_q <= 1'b0;
        sweep_q         <= 1'b0;
        unique_q        <= 4'd0;
        full_q          <= syn_open_q;
      end
      RES_FULL: begin
        ignored_q       <= 1'b0;
        pattern_q       <= pat_q;
        count_q         <= cnt_q;
        stealth_alert_q <= salert_q;
        sweep_q         <= walert;
        unique_q        <= syn_open_q ? 4'(n_fin) : 4'd0;
        full_q          <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o    = res_valid_q;
  assign ignored_o         = ignored_q;
  assign stealth_pattern_o = pattern_q;
  assign stealth_count_o   = count_q;
  assign stealth_alert_o   = stealth_alert_q;
  assign sweep_alert_o     = sweep_q;
  assign unique_ports_o    = unique_q;
  assign table_full_o      = full_q;

  // A stealth alert only comes with a counted hit.
  `TPSD_ASSERT_IMP(a_alert_has_pattern, res_valid_q && stealth_alert_q, pattern_q)
  // An ignored frame reports no stealth pattern, sweep or full table.
  `TPSD_ASSERT_IMP(a_ignored_alone, res_valid_q && ignored_q, !pattern_q && !sweep_q && !full_q)
  // The slot walk never reads past the stored ports.
  `TPSD_ASSERT_IMP(a_slot_in_range, cmd_i.slot_step, CW'(k_q) < n_q)
  // Every commit produces a result transfer.
  `TPSD_ASSERT_NEXT(a_commit_strobes, cmd_i.commit, res_valid_q)

endmodule

>>> tb/testbench.sv
module testbench;
  import tpsd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // One parsed packet header as presented to the detector.
  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  ip_protocol;
    logic [3:0]  header_words;
    logic [31:0] source_address;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic        ack_flag;
    logic        rst_flag;
    logic [31:0] now_seconds;
  } header_t;

  // One verdict produced for a header.
  typedef struct packed {
    logic       ignored;
    logic       stealth_pattern;
    logic [3:0] stealth_count;
    logic       stealth_alert;
    logic       sweep_alert;
    logic [3:0] unique_ports;
    logic       table_full;
  } verdict_t;

  // Shadow copy of the source table, and the queue of verdicts still to arrive.
  class scan_scoreboard;
    logic [7:0]  window_s;
    logic [2:0]  port_thr;
    logic [7:0]  syn_rst_s;
    logic [3:0]  stealth_thr;
    bit          src_valid [64];
    logic [31:0] src_addr [64];
    logic [31:0] first_syn [64];
    logic [31:0] last_syn [64];
    logic [3:0]  hits [64];
    int unsigned nports [64];
    logic [15:0] ports [64][8];
    verdict_t    pending [$];
    int unsigned errors;

    function new();
      window_s = WINDOW_RESET;
      port_thr = PORT_THR_RESET;
      syn_rst_s = SYN_RST_RESET;
      stealth_thr = STEALTH_THR_RESET;
      foreach (src_valid[i]) src_valid[i] = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] val);
      case (idx)
        CFG_WINDOW:      window_s = val;
        CFG_PORT_THR:    port_thr = val[2:0];
        CFG_SYN_RST:     syn_rst_s = val;
        CFG_STEALTH_THR: stealth_thr = val[3:0];
        default: ;
      endcase
    endfunction

    function int lookup(logic [31:0] addr);
      for (int i = 0; i < 64; i++)
        if (src_valid[i] && src_addr[i] == addr) return i;
      return -1;
    endfunction

    // Works out the verdict of an accepted header and updates the shadow table.
    function void note_header(header_t h);
      verdict_t v;
      int e;
      logic [3:0] c;
      int unsigned n;
      bit seen;
      v = '0;
      if (h.frame_length < 16'd34 || h.ip_protocol != PROTO_TCP ||
          32'(h.frame_length) < 32'd34 + 32'(h.header_words) * 4) begin
        v.ignored = 1'b1;
        pending.push_back(v);
        return;
      end
      // The RST check runs before the SYN update.
      if (h.rst_flag) begin
        e = lookup(h.source_address);
        if (e >= 0 && last_syn[e] != 0 &&
            (h.now_seconds - last_syn[e]) <= 32'(syn_rst_s)) begin
          c = hits[e] + 4'd1;
          v.stealth_pattern = 1'b1;
          v.stealth_count = c;
          if (c >= stealth_thr) begin
            v.stealth_alert = 1'b1;
            c = 4'd0;
          end
          hits[e] = c;
        end
      end
      if (h.syn_flag && !h.ack_flag) begin
        e = lookup(h.source_address);
        if (e < 0) begin
          for (int i = 0; i < 64; i++)
            if (!src_valid[i]) begin
              e = i;
              break;
            end
          if (e >= 0) begin
            src_valid[e] = 1'b1;
            src_addr[e] = h.source_address;
            first_syn[e] = 32'd0;
            last_syn[e] = 32'd0;
            hits[e] = 4'd0;
            nports[e] = 0;
          end
        end
        if (e < 0) begin
          v.table_full = 1'b1;
        end else begin
          if (first_syn[e] == 0 || (h.now_seconds - first_syn[e]) > 32'(window_s)) begin
            first_syn[e] = h.now_seconds;
            nports[e] = 0;
          end
          last_syn[e] = h.now_seconds;
          n = nports[e];
          seen = 1'b0;
          for (int k = 0; k < n; k++)
            if (ports[e][k] == h.dest_port) seen = 1'b1;
          if (!seen && n < 8) begin
            ports[e][n] = h.dest_port;
            n++;
          end
          nports[e] = n;
          v.unique_ports = 4'(n);
          if (n > port_thr) begin
            v.sweep_alert = 1'b1;
            nports[e] = 0;
          end
        end
      end
      pending.push_back(v);
    endfunction

    // Compares one received verdict with the oldest one expected.
    function void check_verdict(verdict_t got);
      verdict_t exp_v;
      if (pending.size() == 0) begin
        $error("verdict with none expected: %h", got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.ignored !== exp_v.ignored) begin
        $error("ignored: expected %0d, got %0d", exp_v.ignored, got.ignored);
        errors++;
      end
      if (got.stealth_pattern !== exp_v.stealth_pattern) begin
        $error("stealth_pattern: expected %0d, got %0d",
               exp_v.stealth_pattern, got.stealth_pattern);
        errors++;
      end
      if (got.stealth_count !== exp_v.stealth_count) begin
        $error("stealth_count: expected %0d, got %0d",
               exp_v.stealth_count, got.stealth_count);
        errors++;
      end
      if (got.stealth_alert !== exp_v.stealth_alert) begin
        $error("stealth_alert: expected %0d, got %0d",
               exp_v.stealth_alert, got.stealth_alert);
        errors++;
      end
      if (got.sweep_alert !== exp_v.sweep_alert) begin
        $error("sweep_alert: expected %0d, got %0d", exp_v.sweep_alert, got.sweep_alert);
        errors++;
      end
      if (got.unique_ports !== exp_v.unique_ports) begin
        $error("unique_ports: expected %0d, got %0d",
               exp_v.unique_ports, got.unique_ports);
        errors++;
      end
      if (got.table_full !== exp_v.table_full) begin
        $error("table_full: expected %0d, got %0d", exp_v.table_full, got.table_full);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_wdata_i = '0;
  header_t     hdr = '0;
  logic        result_valid_o;
  verdict_t    verdict;

  scan_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  logic [31:0] clock_s = 32'd100;
  logic [31:0] addr_pool [8];

  always #5 clk_i = ~clk_i;

  tcp_port_scan_detector_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .frame_length_i   (hdr.frame_length),
    .ip_protocol_i    (hdr.ip_protocol),
    .header_words_i   (hdr.header_words),
    .source_address_i (hdr.source_address),
    .dest_port_i      (hdr.dest_port),
    .syn_flag_i       (hdr.syn_flag),
    .ack_flag_i       (hdr.ack_flag),
    .rst_flag_i       (hdr.rst_flag),
    .now_seconds_i    (hdr.now_seconds),
    .result_valid_o   (result_valid_o),
    .ignored_o        (verdict.ignored),
    .stealth_pattern_o(verdict.stealth_pattern),
    .stealth_count_o  (verdict.stealth_count),
    .stealth_alert_o  (verdict.stealth_alert),
    .sweep_alert_o    (verdict.sweep_alert),
    .unique_ports_o   (verdict.unique_ports),
    .table_full_o     (verdict.table_full)
  );

  // Check verdicts and record header transfers on the values before each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_verdict(verdict);
      if (start && !busy) sb.note_header(hdr);
      if (result_valid_o || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one header and holds it until the transfer; keep_start leaves start high.
  task automatic send_header(header_t h, bit keep_start);
    hdr <= h;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (!keep_start) start <= 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Waits until every expected verdict has arrived and the block is idle.
  task automatic drain();
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
  endtask

  function automatic header_t tcp_header(logic [31:0] addr, logic [15:0] port,
                                         logic syn, logic ack, logic rst, logic [31:0] now);
    header_t h;
    h.frame_length = 16'd60;
    h.ip_protocol = PROTO_TCP;
    h.header_words = 4'd5;
    h.source_address = addr;
    h.dest_port = port;
    h.syn_flag = syn;
    h.ack_flag = ack;
    h.rst_flag = rst;
    h.now_seconds = now;
    return h;
  endfunction

  // Random header: mostly well-formed scan traffic, from a small set of sources or fresh ones.
  function automatic header_t random_header(bit fresh_source);
    header_t h;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_s = $urandom;
    else clock_s = clock_s + $urandom_range(0, 2);
    h = tcp_header(fresh_source ? $urandom : addr_pool[$urandom_range(0, 7)],
                   16'($urandom_range(0, 11)), 1'b1, 1'b0, 1'b0, clock_s);
    if ($urandom_range(0, 9) == 0) h.dest_port = 16'($urandom);
    h.header_words = 4'($urandom);
    h.frame_length = 16'($urandom_range(94, 1514));
    if (kind < 45) begin
      // SYN scan probe
    end else if (kind < 70) begin
      h.syn_flag = 1'b0;
      h.rst_flag = 1'b1;
    end else if (kind < 78) begin
      h.rst_flag = 1'b1;
    end else if (kind < 85) begin
      h.ack_flag = 1'b1;
      h.rst_flag = 1'($urandom);
    end else if (kind < 92) begin
      {h.syn_flag, h.ack_flag, h.rst_flag} = 3'($urandom);
      h.frame_length = 16'($urandom);
    end else begin
      h.ip_protocol = 8'($urandom);
      h.frame_length = 16'($urandom_range(0, 120));
    end
    return h;
  endfunction

  task automatic random_traffic(int unsigned count, bit fresh_sources);
    int unsigned burst;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        send_header(random_header(fresh_sources), b + 1 < burst && sent + 1 < count);
        sent++;
      end
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
    end
  endtask

  initial begin
    header_t h;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped frames at the field extremes.
    h = tcp_header(32'h0A00_0001, 16'd80, 1'b1, 1'b0, 1'b0, 32'd10);
    h.frame_length = 16'd0;
    send_header(h, 1'b1);
    h.frame_length = 16'd33;
    send_header(h, 1'b1);
    h.frame_length = 16'hFFFF;
    h.ip_protocol = 8'd0;
    send_header(h, 1'b1);
    h.ip_protocol = 8'hFF;
    send_header(h, 1'b1);
    h.ip_protocol = PROTO_TCP;
    h.header_words = 4'd15;
    h.frame_length = 16'd93;
    send_header(h, 1'b0);
    // Largest header that still fits, extreme address and port.
    h.frame_length = 16'd94;
    h.source_address = 32'hFFFF_FFFF;
    h.dest_port = 16'hFFFF;
    send_header(h, 1'b0);
    // RST from an unknown source does nothing.
    send_header(tcp_header(32'h0A00_0099, 16'd1, 1'b0, 1'b0, 1'b1, 32'd10), 1'b0);
    // Stealth hits across the time wrap, then SYN and RST together.
    send_header(tcp_header(32'h0, 16'd0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b1);
    send_header(tcp_header(32'h0, 16'd0, 1'b0, 1'b0, 1'b1, 32'd0), 1'b1);
    send_header(tcp_header(32'h0, 16'd1, 1'b1, 1'b0, 1'b1, 32'd0), 1'b1);
    send_header(tcp_header(32'h0, 16'd2, 1'b1, 1'b0, 1'b1, 32'd1), 1'b1);
    // Late RST and an earlier timestamp.
    send_header(tcp_header(32'h0, 16'd3, 1'b0, 1'b0, 1'b1, 32'd9), 1'b1);
    send_header(tcp_header(32'h0, 16'd3, 1'b1, 1'b0, 1'b0, 32'd0), 1'b1);
    // Sweep: new ports past the threshold, then port 0 once more; SYN+ACK is not a probe.
    for (int p = 0; p < 7; p++)
      send_header(tcp_header(32'h0A00_0002, 16'(p % 6), 1'b1, 1'b0, 1'b0, 32'd50), 1'b1);
    send_header(tcp_header(32'h0A00_0002, 16'd9, 1'b1, 1'b1, 1'b0, 32'd50), 1'b0);
    drain();

    // Random phases over several register settings, extremes included.
    random_traffic(60, 1'b0);
    drain();
    write_reg(CFG_WINDOW, 8'd0);
    write_reg(CFG_PORT_THR, 8'd1);
    write_reg(CFG_SYN_RST, 8'd0);
    write_reg(CFG_STEALTH_THR, 8'd1);
    random_traffic(70, 1'b0);
    drain();
    write_reg(CFG_WINDOW, 8'd255);
    write_reg(CFG_PORT_THR, 8'd7);
    write_reg(CFG_SYN_RST, 8'd255);
    write_reg(CFG_STEALTH_THR, 8'd15);
    random_traffic(80, 1'b0);
    drain();
    // Flood of new sources fills the table; later new sources are not tracked.
    write_reg(CFG_WINDOW, 8'd3);
    write_reg(CFG_PORT_THR, 8'd2);
    write_reg(CFG_SYN_RST, 8'd2);
    write_reg(CFG_STEALTH_THR, 8'd2);
    for (int i = 0; i < 70; i++)
      send_header(tcp_header($urandom, 16'($urandom), 1'b1, 1'b0, 1'b0, clock_s), i < 69);
    random_traffic(20, 1'b1);
    drain();
    write_reg(CFG_WINDOW, 8'd10);
    write_reg(CFG_PORT_THR, 8'd3);
    write_reg(CFG_SYN_RST, 8'd5);
    write_reg(CFG_STEALTH_THR, 8'd4);
    random_traffic(80, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tpsd_pkg.sv
rtl/tpsd_ctrl.sv
rtl/tpsd_datapath.sv
rtl/tcp_port_scan_detector_core.sv
tb/testbench.sv
